// File: sv/sti_pkg.sv
// Shared types and operation codes for the sorted table block.
package sti_pkg;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_SORT     = 2'd1;
    localparam logic [1:0] OP_SEQ_FIND = 2'd2;
    localparam logic [1:0] OP_BIN_FIND = 2'd3;

    localparam int POSITION_W = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_RD,
        ST_SORT_CUR,
        ST_SORT_CMP,
        ST_SORT_PLACE,
        ST_SEQ_RD,
        ST_SEQ_CMP,
        ST_BIN_PROBE,
        ST_BIN_CMP
    } sti_state_t;

endpackage

// File: sv/sorted_table_insert_search.sv
// Sorted table: insert, insertion sort, sequential and binary search over one memory.
//
//  channel   ports                          handshake
//  -------   -----------------------------  -----------------------------------
//  command   opcode[1:0], value[31:0]       taken when start && !busy
//  result    found, position[3:0], status   one cycle, marked by done
//
// Insert does not make the block busy; the next command may follow at once.
// Sequential search reads and compares each entry visited; binary search reads and compares at each probe.
// Sort is an insertion sort stepping through SORT_RD, SORT_CUR, SORT_CMP and SORT_PLACE;
// the single read port of the table memory paces these steps.
// Reset empties the table at once (fill count cleared); entries are not cleared.
// The result is shown for one cycle and cannot be held off by the receiver.
module sorted_table_insert_search #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic signed [31:0] value,
    output logic        done,
    output logic        found,
    output logic [sti_pkg::POSITION_W-1:0] position,
    output logic        status
);
    import sti_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    // Table memory, one write and one registered read per cycle.
    logic signed [31:0] mem [TABLE_DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic signed [31:0] wr_data;

    sti_state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic signed [31:0] cur_reg, cur_next;
    logic signed [31:0] key_reg, key_next;
    logic done_reg, done_next;
    logic found_reg, found_next;
    logic [POSITION_W-1:0] position_reg, position_next;
    logic status_reg, status_next;

    logic             accept;
    logic [CNT_W-1:0] k_dec, k_dec2, j_inc, k_inc;
    logic [CNT_W:0]   mid_sum;
    logic [IDX_W-1:0] mid_calc;

    assign accept   = start && (state_reg == ST_IDLE);
    assign k_dec    = k_reg - CNT_ONE;
    assign k_dec2   = k_reg - CNT_TWO;
    assign k_inc    = k_reg + CNT_ONE;
    assign j_inc    = j_reg + CNT_ONE;
    // hi_reg holds the upper bound plus one, so it never goes negative.
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W+1)'(1);
    assign mid_calc = mid_sum[IDX_W:1];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        j_reg        <= j_next;
        k_reg        <= k_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        cur_reg      <= cur_next;
        key_reg      <= key_next;
        found_reg    <= found_next;
        position_reg <= position_next;
        status_reg   <= status_next;
    end

    // Next state and datapath registers.
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        cur_next      = cur_reg;
        key_next      = key_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        position_next = position_reg;
        status_next   = status_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    key_next      = value;
                    found_next    = 1'b0;
                    position_next = '0;
                    status_next   = 1'b0;
                    unique case (opcode)
                        OP_INSERT: begin
                            done_next = 1'b1;
                            if (fill_reg == CNT_FULL) begin
                                status_next = 1'b1;
                            end else begin
                                position_next = POSITION_W'(fill_reg);
                                fill_next     = fill_reg + CNT_ONE;
                            end
                        end
                        OP_SORT: begin
                            if (fill_reg > CNT_ONE) begin
                                j_next     = CNT_ONE;
                                state_next = ST_SORT_RD;
                            end else begin
                                done_next = 1'b1;
                            end
                        end
                        OP_SEQ_FIND: begin
                            if (fill_reg == '0) begin
                                done_next = 1'b1;
                            end else begin
                                k_next     = '0;
                                state_next = ST_SEQ_RD;
                            end
                        end
                        OP_BIN_FIND: begin
                            lo_next    = '0;
                            hi_next    = fill_reg;
                            state_next = ST_BIN_PROBE;
                        end
                    endcase
                end
            end
            ST_SORT_RD: begin
                k_next     = j_reg;
                state_next = ST_SORT_CUR;
            end
            ST_SORT_CUR: begin
                cur_next   = rd_data_reg;
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                if (rd_data_reg > cur_reg) begin
                    k_next = k_dec;
                    if (k_reg == CNT_ONE) begin
                        state_next = ST_SORT_PLACE;
                    end
                end else begin
                    j_next = j_inc;
                    if (j_inc < fill_reg) begin
                        state_next = ST_SORT_RD;
                    end else begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SORT_PLACE: begin
                j_next = j_inc;
                if (j_inc < fill_reg) begin
                    state_next = ST_SORT_RD;
                end else begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEQ_RD: begin
                state_next = ST_SEQ_CMP;
            end
            ST_SEQ_CMP: begin
                if (rd_data_reg == key_reg) begin
                    found_next    = 1'b1;
                    position_next = POSITION_W'(k_reg);
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end else if (k_inc < fill_reg) begin
                    k_next     = k_inc;
                    state_next = ST_SEQ_RD;
                end else begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_BIN_PROBE: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_calc;
                    state_next = ST_BIN_CMP;
                end else begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_BIN_CMP: begin
                if (rd_data_reg == key_reg) begin
                    found_next    = 1'b1;
                    position_next = POSITION_W'(mid_reg);
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    if (key_reg < rd_data_reg) begin
                        hi_next = CNT_W'(mid_reg);
                    end else begin
                        lo_next = CNT_W'(mid_reg) + CNT_ONE;
                    end
                    state_next = ST_BIN_PROBE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory port controls.
    always_comb begin
        rd_addr = k_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = k_reg[IDX_W-1:0];
        wr_data = cur_reg;

        unique case (state_reg)
            ST_IDLE: begin
                wr_addr = fill_reg[IDX_W-1:0];
                wr_data = value;
                wr_en   = start && (opcode == OP_INSERT) && (fill_reg != CNT_FULL);
            end
            ST_SORT_RD: begin
                rd_addr = j_reg[IDX_W-1:0];
            end
            ST_SORT_CUR: begin
                rd_addr = k_dec[IDX_W-1:0];
            end
            ST_SORT_CMP: begin
                // Shift the larger entry up while fetching the next one down; else place the held entry.
                wr_en   = 1'b1;
                rd_addr = k_dec2[IDX_W-1:0];
                if (rd_data_reg > cur_reg) begin
                    wr_data = rd_data_reg;
                end
            end
            ST_SORT_PLACE: begin
                wr_en = 1'b1;
            end
            ST_SEQ_RD: begin
                rd_addr = k_reg[IDX_W-1:0];
            end
            ST_SEQ_CMP: begin
                rd_addr = k_reg[IDX_W-1:0];
            end
            ST_BIN_PROBE: begin
                rd_addr = mid_calc;
            end
            ST_BIN_CMP: begin
                rd_addr = mid_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;
    assign status   = status_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_FULL)
        else $error("fill count exceeds table depth");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(accept) || $past(busy))
        else $error("result word without a command");

    a_full_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg) |-> !found_reg && $past(fill_reg) == CNT_FULL)
        else $error("full status on a table that was not full");

    a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> accept || state_reg == ST_SORT_CMP || state_reg == ST_SORT_PLACE)
        else $error("table written outside insert or sort");

    a_fill_sort_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> fill_reg == $past(fill_reg))
        else $error("fill count changed during a multi-cycle operation");

endmodule

// File: tb/sorted_table_insert_search_tb.sv
// Testbench for the sorted table: directed words, then random words, checked by a predictor or by typed results.
module sorted_table_insert_search_tb;
    import sti_pkg::*;

    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
        logic                  status;
    } table_result_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] val;
        logic               typed;
        table_result_t      res;
    } stim_row_t;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 1525;
    localparam int CALM_TAIL    = 200;
    localparam int DRAIN_CYCLES = 400;
    localparam int MAX_REPORTS  = 10;

    logic               clk    = 1'b0;
    logic               rst_n  = 1'b0;
    logic               start  = 1'b0;
    logic [1:0]         opcode = OP_INSERT;
    logic signed [31:0] value  = '0;
    logic               busy;
    logic               done;
    logic               found;
    logic [POSITION_W-1:0] position;
    logic               status;

    // Typed-in expectation that travels with the word on the command side.
    logic               word_typed  = 1'b0;
    table_result_t      word_expect = '0;

    logic signed [31:0] model_tbl [DEPTH];
    int                 model_fill = 0;
    table_result_t      pending_results [$];
    logic signed [31:0] key_pool [$];

    int error_count  = 0;
    int words_taken  = 0;
    int insert_count = 0;
    int reject_count = 0;
    int sort_count   = 0;
    int search_count = 0;
    int hit_count    = 0;

    sorted_table_insert_search #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .opcode   (opcode),
        .value    (value),
        .done     (done),
        .found    (found),
        .position (position),
        .status   (status)
    );

    always #5 clk = ~clk;

    function automatic table_result_t predict_table_op(logic [1:0] op, logic signed [31:0] key);
        table_result_t      r;
        logic signed [31:0] cur;
        int                 j;
        int                 k;
        int                 lo;
        int                 hi;
        int                 mid;
        r = '0;
        case (op)
            OP_INSERT:
            begin
                if (model_fill >= DEPTH)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    model_tbl[model_fill] = key;
                    r.position = POSITION_W'(model_fill);
                    model_fill++;
                end
            end
            OP_SORT:
            begin
                for (j = 1; j < model_fill; j++)
                begin
                    cur = model_tbl[j];
                    k = j;
                    while (k > 0 && model_tbl[k-1] > cur)
                    begin
                        model_tbl[k] = model_tbl[k-1];
                        k--;
                    end
                    model_tbl[k] = cur;
                end
            end
            OP_SEQ_FIND:
            begin
                for (k = 0; k < model_fill && !r.found; k++)
                begin
                    if (model_tbl[k] == key)
                    begin
                        r.found = 1'b1;
                        r.position = POSITION_W'(k);
                    end
                end
            end
            default:
            begin
                lo = 0;
                hi = model_fill - 1;
                while (lo <= hi && !r.found)
                begin
                    mid = (lo + hi) / 2;
                    if (model_tbl[mid] == key)
                    begin
                        r.found = 1'b1;
                        r.position = POSITION_W'(mid);
                    end
                    else if (key < model_tbl[mid])
                    begin
                        hi = mid - 1;
                    end
                    else
                    begin
                        lo = mid + 1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Prediction on acceptance comes before the result check; a result may fall in the
    // same cycle as the next word is taken.
    always @(posedge clk)
    begin : check_results
        table_result_t want;
        table_result_t got;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want = predict_table_op(opcode, value);
                if (word_typed)
                    want = word_expect;
                pending_results.push_back(want);
                words_taken++;
                case (opcode)
                    OP_INSERT: insert_count++;
                    OP_SORT:   sort_count++;
                    default:   search_count++;
                endcase
            end
            if (done)
            begin
                got = {found, position, status};
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result: found=%0d position=%0d status=%0d",
                                 found, position, status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found || got.position !== want.position ||
                        got.status !== want.status)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("mismatch: found %0d/%0d position %0d/%0d status %0d/%0d",
                                     want.found, got.found, want.position, got.position,
                                     want.status, got.status);
                    end
                    if (got.found === 1'b1)
                        hit_count++;
                    if (got.status === 1'b1)
                        reject_count++;
                end
            end
        end
    end

    function automatic stim_row_t mk_row(logic [1:0] op, logic [31:0] val, logic typed,
                                         logic f, logic [POSITION_W-1:0] p, logic s);
        stim_row_t row;
        row.op = op;
        row.val = val;
        row.typed = typed;
        row.res = {f, p, s};
        return row;
    endfunction

    // Keys are mostly table members or their neighbors, so searches hit often.
    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] k;
        int                 r;
        r = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 55)
            return k;
        if (r < 70)
            return ($urandom_range(0, 1) != 0) ? k + 1 : k - 1;
        if (r < 80)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh0;
                default: return -32'sh1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic signed [31:0] val,
                             input logic typed, input table_result_t res);
        opcode      <= op;
        value       <= val;
        word_typed  <= typed;
        word_expect <= res;
        start       <= 1'b1;
        if (op == OP_INSERT && key_pool.size() < DEPTH)
            key_pool.push_back(val);
        do
            @(posedge clk);
        while (!(start && !busy));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin : stimulus
        stim_row_t rows [$];
        int        n;
        int        r;
        bit        calm;
        logic [1:0] op;

        // Empty table first, then a partial fill with the extremes, searches on unsorted
        // data, a sort, a fill to full with duplicates, a refused insert and searches.
        rows.push_back(mk_row(OP_SEQ_FIND, 32'h0000_0000, 1, 0, 0, 0));
        rows.push_back(mk_row(OP_BIN_FIND, 32'h7FFF_FFFF, 1, 0, 0, 0));
        rows.push_back(mk_row(OP_SORT,     32'h0000_0000, 1, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h7FFF_FFFF, 1, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h8000_0000, 1, 0, 1, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h0000_0000, 1, 0, 2, 0));
        rows.push_back(mk_row(OP_INSERT,   32'hFFFF_FFFF, 1, 0, 3, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h0000_0001, 1, 0, 4, 0));
        rows.push_back(mk_row(OP_BIN_FIND, 32'h8000_0000, 0, 0, 0, 0));
        rows.push_back(mk_row(OP_SEQ_FIND, 32'h8000_0000, 1, 1, 1, 0));
        rows.push_back(mk_row(OP_SORT,     32'h0000_0000, 1, 0, 0, 0));
        rows.push_back(mk_row(OP_BIN_FIND, 32'h8000_0000, 0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT,   32'hAAAA_AAAA, 1, 0, 5, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h5555_5555, 1, 0, 6, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h8000_0000, 1, 0, 7, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h7FFF_FFFE, 1, 0, 8, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h8000_0001, 1, 0, 9, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h1234_5678, 1, 0, 10, 0));
        rows.push_back(mk_row(OP_INSERT,   32'hEDCB_A987, 1, 0, 11, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h0000_0001, 1, 0, 12, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h0000_FFFF, 1, 0, 13, 0));
        rows.push_back(mk_row(OP_INSERT,   32'hFFFF_0000, 1, 0, 14, 0));
        rows.push_back(mk_row(OP_INSERT,   32'hDEAD_BEEF, 1, 0, 15, 0));
        rows.push_back(mk_row(OP_INSERT,   32'h0000_0000, 1, 0, 0, 1));
        rows.push_back(mk_row(OP_SEQ_FIND, 32'h0000_0001, 0, 0, 0, 0));
        rows.push_back(mk_row(OP_SEQ_FIND, 32'h0000_0003, 1, 0, 0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_word(rows[i].op, rows[i].val, rows[i].typed, rows[i].res);
            if ($urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 18));
        end

        // The table stays full from here on; sorts are kept rare so that the
        // appended tail stays unsorted for a while.
        calm = 1'b0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
                calm = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 10)
                op = OP_INSERT;
            else if (r < 15)
                op = OP_SORT;
            else if (r < 57)
                op = OP_SEQ_FIND;
            else
                op = OP_BIN_FIND;
            send_word(op, pick_key(), 1'b0, '0);
            if (!calm && n < RANDOM_WORDS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 18));
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        error_count += pending_results.size();

        $display("%0d words taken: %0d inserts (%0d refused on a full table), %0d sorts,",
                 words_taken, insert_count, reject_count, sort_count);
        $display("%0d searches with %0d hits, %0d errors", search_count, hit_count, error_count);
        if (error_count == 0)
            $display("sorted_table_insert_search_tb OK");
        else
            $display("sorted_table_insert_search_tb NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("sorted_table_insert_search_tb NOT OK");
        $finish;
    end

endmodule
